// ----- rtl/scor_pkg.sv -----
package scor_pkg;

    // field widths and filter length
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int FILTER_TAPS = 3;
    localparam int NUM_REGS    = 3;
    localparam int NUM_LANES   = 3;

    // derived widths
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = PROD_W + COEF_W - 1 + $clog2(FILTER_TAPS + 1);
    localparam int MAG_W    = ACC_W - 1;
    localparam int NORM_W   = 30;
    localparam int ROOT_W   = NORM_W;
    localparam int X_W      = 2 * NORM_W;
    localparam int QUOT_W   = SAMPLE_W;
    localparam int FRAC_SHIFT = SAMPLE_W - 1;
    localparam int TAP_W    = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
    localparam int IDX_W    = ADDR_W - 2;

    // lanes of the filter
    localparam int LANE_X     = 0;
    localparam int LANE_LEFT  = 1;
    localparam int LANE_RIGHT = 2;

    // taps counted in steps back
    localparam int TAP_NEWEST = 0;
    localparam int TAP_MIDDLE = 1;
    localparam int TAP_OLDEST = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TAP_OLDEST = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_TAP_MIDDLE = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_TAP_NEWEST = IDX_W'(2);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic        [MAG_W-1:0]    mag_t;
    typedef logic        [NORM_W-1:0]   norm_t;
    typedef logic        [X_W-1:0]      xval_t;
    typedef logic        [QUOT_W-1:0]   quot_t;

    localparam coef_t COEF_RESET = COEF_W'(21845);

    typedef struct packed {
        acc_t xprod;
        acc_t left_pow;
        acc_t right_pow;
    } fir_sums_t;

endpackage

// ----- rtl/scor_fir.sv -----
module scor_fir import scor_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  sample_t   left_in,
    input  sample_t   right_in,
    input  coef_t     coef [FILTER_TAPS],
    output logic      done,
    output fir_sums_t sums
);

    localparam int BIT_W = $clog2(COEF_W);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_PROD = 3'b010,
        F_MAC  = 3'b100
    } fir_state_t;

    fir_state_t       state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    coef_t            csh_reg, csh_next;
    logic             done_reg, done_next;
    sample_t          left_line_reg  [FILTER_TAPS];
    sample_t          right_line_reg [FILTER_TAPS];
    acc_t             mcand_reg [NUM_LANES];
    acc_t             mcand_next [NUM_LANES];
    acc_t             acc_reg [NUM_LANES];
    acc_t             acc_next [NUM_LANES];

    sample_t l_tap, r_tap;
    prod_t   prod_lr, prod_ll, prod_rr;
    logic    last_bit;

    assign l_tap    = left_line_reg[tap_reg];
    assign r_tap    = right_line_reg[tap_reg];
    assign prod_lr  = l_tap * r_tap;
    assign prod_ll  = l_tap * l_tap;
    assign prod_rr  = r_tap * r_tap;
    assign last_bit = (bit_reg == BIT_W'(COEF_W - 1));

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        bit_next   = bit_reg;
        csh_next   = csh_reg;
        done_next  = 1'b0;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (load)
                begin
                    tap_next   = '0;
                    for (int i = 0; i < NUM_LANES; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    state_next = F_PROD;
                end
            end
            F_PROD:
            begin
                mcand_next[LANE_X]     = acc_t'(prod_lr);
                mcand_next[LANE_LEFT]  = acc_t'(prod_ll);
                mcand_next[LANE_RIGHT] = acc_t'(prod_rr);
                csh_next   = coef[tap_reg];
                bit_next   = '0;
                state_next = F_MAC;
            end
            F_MAC:
            begin
                // one coefficient bit per cycle, sign bit weighs negative
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    if (csh_reg[0])
                    begin
                        acc_next[i] = last_bit ? acc_reg[i] - mcand_reg[i]
                                               : acc_reg[i] + mcand_reg[i];
                    end
                    mcand_next[i] = mcand_reg[i] <<< 1;
                end
                csh_next = csh_reg >>> 1;
                bit_next = bit_reg + 1'b1;
                if (last_bit)
                begin
                    if (tap_reg == TAP_W'(FILTER_TAPS - 1))
                    begin
                        done_next  = 1'b1;
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        tap_next   = tap_reg + 1'b1;
                        state_next = F_PROD;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            tap_reg   <= '0;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
            for (int k = 0; k < FILTER_TAPS; k++)
            begin
                left_line_reg[k]  <= '0;
                right_line_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            bit_reg   <= bit_next;
            done_reg  <= done_next;
            if (load)
            begin
                left_line_reg[0]  <= left_in;
                right_line_reg[0] <= right_in;
                for (int k = 1; k < FILTER_TAPS; k++)
                begin
                    left_line_reg[k]  <= left_line_reg[k-1];
                    right_line_reg[k] <= right_line_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        csh_reg   <= csh_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    assign done            = done_reg;
    assign sums.xprod      = acc_reg[LANE_X];
    assign sums.left_pow   = acc_reg[LANE_LEFT];
    assign sums.right_pow  = acc_reg[LANE_RIGHT];

endmodule

// ----- rtl/scor_sqrt.sv -----
module scor_sqrt import scor_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  xval_t x,
    output logic  done,
    output norm_t root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    xval_t            x_reg, x_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    norm_t            root_reg, root_next;

    logic [SH_W-1:0]  rem_shift;
    logic [SH_W-1:0]  trial;
    logic             fits;

    // two radicand bits per step
    assign rem_shift = {rem_reg, x_reg[X_W-1:X_W-2]};
    assign trial     = SH_W'({root_reg, 2'b01});
    assign fits      = (rem_shift >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = x;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            x_next    = x_reg << 2;
            rem_next  = fits ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/scor_div.sv -----
module scor_div import scor_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  norm_t num,
    input  norm_t den,
    output logic  done,
    output logic  ovf,
    output quot_t quot
);

    localparam int NUM_EXT_W = NORM_W + FRAC_SHIFT;
    localparam int HI_W      = NUM_EXT_W - QUOT_W;
    localparam int CNT_W     = $clog2(QUOT_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    norm_t            rem_reg, rem_next;
    norm_t            den_reg, den_next;
    quot_t            bits_reg, bits_next;
    quot_t            quot_reg, quot_next;

    logic [NUM_EXT_W-1:0] num_ext;
    logic [HI_W-1:0]      num_hi;
    logic [NORM_W:0]      rem2;
    logic                 ge;

    // numerator is num scaled by 2^15; its high part starts the remainder
    assign num_ext = {num, {FRAC_SHIFT{1'b0}}};
    assign num_hi  = num_ext[NUM_EXT_W-1:QUOT_W];
    assign rem2    = {rem_reg, bits_reg[QUOT_W-1]};
    assign ge      = (rem2 >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            // quotient would need more than QUOT_W bits
            ovf_next  = (NORM_W'(num_hi) >= den);
            rem_next  = NORM_W'(num_hi);
            den_next  = den;
            bits_next = num_ext[QUOT_W-1:0];
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? NORM_W'(rem2 - {1'b0, den_reg}) : NORM_W'(rem2);
            bits_next = bits_reg << 1;
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg  <= ovf_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/stereo_correlation_core.sv -----
// channel  signals                            request moves
// in       in_valid in_ready                  left_sample, right_sample
// out      out_valid out_ready                correlation
// cfg      psel penable pwrite paddr pready   pwdata / prdata (three tap weights)
//
// a request passes through the filter, normalizing, the square root and the divider
// in that order; when an energy is zero or the two energies differ in sign, the root
// and divide are skipped. the serial coefficient multiply-accumulate works tap by tap,
// normalizing shifts the magnitudes right one bit per step, the square root retires
// two radicand bits a cycle and the divider one quotient bit a cycle.
// reset clears the sample history and loads every tap weight with 21845.
// a new request is taken while a result waits in the output register; a second
// finished result waits in the last state until that register is free.
module stereo_correlation_core import scor_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sample_t           left_sample,
    input  sample_t           right_sample,
    output logic              out_valid,
    input  logic              out_ready,
    output sample_t           correlation,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_FIR  = 7'b0000010,
        S_NORM = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam quot_t   NEG_LIMIT  = {1'b1, {(QUOT_W-1){1'b0}}};

    state_t                 state_reg, state_next;
    coef_t                  coef_reg [FILTER_TAPS];
    mag_t                   mag_reg  [NUM_LANES];
    mag_t                   mag_next [NUM_LANES];
    logic [NUM_LANES-1:0]   neg_reg, neg_next;
    sample_t                res_reg, res_next;
    sample_t                corr_reg, corr_next;
    logic                   out_valid_reg, out_valid_next;

    fir_sums_t              sums;
    logic                   fir_done;
    logic                   in_take;
    logic                   sqrt_start, sqrt_done;
    norm_t                  sqrt_root;
    logic                   div_start, div_done, div_ovf;
    quot_t                  div_quot;
    norm_t                  a0, a1, a2;
    xval_t                  energy_prod;
    logic                   need_shift;
    logic                   zero_energy;
    logic                   out_load;
    logic                   cfg_wr;
    logic [IDX_W-1:0]       cfg_idx;

    function automatic mag_t magnitude(acc_t h);
        acc_t n;
        n = -h;
        return h[ACC_W-1] ? MAG_W'(n) : MAG_W'(h);
    endfunction

    function automatic sample_t saturate(logic neg, logic ovf, quot_t m);
        sample_t r;
        if (neg)
        begin
            priority if (ovf || (m > NEG_LIMIT))
                r = SAMPLE_MIN;
            else
                r = sample_t'(QUOT_W'(0) - m);
        end
        else
        begin
            priority if (ovf || m[QUOT_W-1])
                r = SAMPLE_MAX;
            else
                r = sample_t'(m);
        end
        return r;
    endfunction

    // ---------------- configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FILTER_TAPS; k++)
            begin
                coef_reg[k] <= COEF_RESET;
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TAP_OLDEST: coef_reg[TAP_OLDEST] <= pwdata[COEF_W-1:0];
                REG_TAP_MIDDLE: coef_reg[TAP_MIDDLE] <= pwdata[COEF_W-1:0];
                REG_TAP_NEWEST: coef_reg[TAP_NEWEST] <= pwdata[COEF_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TAP_OLDEST: prdata = DATA_W'(coef_reg[TAP_OLDEST]);
            REG_TAP_MIDDLE: prdata = DATA_W'(coef_reg[TAP_MIDDLE]);
            REG_TAP_NEWEST: prdata = DATA_W'(coef_reg[TAP_NEWEST]);
            default:        prdata = '0;
        endcase
    end

    // ---------------- datapath units
    assign in_ready = (state_reg == S_IDLE);
    assign in_take  = in_valid && in_ready;

    scor_fir u_fir (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_take),
        .left_in  (left_sample),
        .right_in (right_sample),
        .coef     (coef_reg),
        .done     (fir_done),
        .sums     (sums)
    );

    assign a0 = mag_reg[LANE_X][NORM_W-1:0];
    assign a1 = mag_reg[LANE_LEFT][NORM_W-1:0];
    assign a2 = mag_reg[LANE_RIGHT][NORM_W-1:0];

    assign energy_prod = X_W'(a1) * X_W'(a2);

    scor_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (energy_prod),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    scor_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (a0),
        .den   (sqrt_root),
        .done  (div_done),
        .ovf   (div_ovf),
        .quot  (div_quot)
    );

    // largest magnitude must end below 2^NORM_W
    assign need_shift = (|mag_reg[LANE_X][MAG_W-1:NORM_W])
                      || (|mag_reg[LANE_LEFT][MAG_W-1:NORM_W])
                      || (|mag_reg[LANE_RIGHT][MAG_W-1:NORM_W]);

    assign zero_energy = (a1 == '0) || (a2 == '0)
                       || (neg_reg[LANE_LEFT] != neg_reg[LANE_RIGHT]);

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // ---------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_FIR;
                end
            end
            S_FIR:
            begin
                if (fir_done)
                begin
                    mag_next[LANE_X]     = magnitude(sums.xprod);
                    mag_next[LANE_LEFT]  = magnitude(sums.left_pow);
                    mag_next[LANE_RIGHT] = magnitude(sums.right_pow);
                    neg_next[LANE_X]     = sums.xprod[ACC_W-1];
                    neg_next[LANE_LEFT]  = sums.left_pow[ACC_W-1];
                    neg_next[LANE_RIGHT] = sums.right_pow[ACC_W-1];
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (need_shift)
                begin
                    for (int i = 0; i < NUM_LANES; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (zero_energy)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = saturate(neg_reg[LANE_X], div_ovf, div_quot);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        corr_next      = corr_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            corr_next      = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
        corr_reg <= corr_next;
    end

    assign out_valid   = out_valid_reg;
    assign correlation = corr_reg;

    // ---------------- checks
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block still ready right after taking a request");

    a_fir_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        fir_done |-> state_reg == S_FIR)
        else $error("filter finished outside the filter phase");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV && !in_ready)
        else $error("divider finished outside the divide phase");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid && !out_ready
        |=> state_reg == S_DONE && out_valid)
        else $error("finished result left its state while output was full");

endmodule
